// ----- rtl/adcf_pkg.sv -----
// Shared types, register codes and reset values for the drive/crush/flanger chain.
`timescale 1ns / 1ps
`default_nettype none

package adcf_pkg;

    localparam int ADC_W      = 10;
    localparam int DUTY_W     = 8;
    localparam int SIG_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    typedef logic signed [SIG_W-1:0] sig_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASELINE,
        CFG_NOISE_FLOOR,
        CFG_DRIVE_GAIN,
        CFG_CRUSH_BITS,
        CFG_SWEEP_DEPTH,
        CFG_SWEEP_RATE,
        CFG_EFFECT_EN
    } cfg_idx_t;

    localparam int EN_DRIVE  = 0;
    localparam int EN_CRUSH  = 1;
    localparam int EN_FLANGE = 2;

    localparam logic [9:0] BASELINE_RST    = 10'd290;
    localparam logic [9:0] NOISE_FLOOR_RST = 10'd50;
    localparam logic [3:0] DRIVE_GAIN_RST  = 4'd4;
    localparam logic [3:0] CRUSH_BITS_RST  = 4'd5;
    localparam logic [5:0] SWEEP_DEPTH_RST = 6'd30;
    localparam logic [1:0] SWEEP_RATE_RST  = 2'd1;
    localparam logic [2:0] EFFECT_EN_RST   = 3'd1;

endpackage

`default_nettype wire

// ----- rtl/adcf_in_if.sv -----
// Sample input channel: valid/ready handshake carrying one converter sample.
`timescale 1ns / 1ps
`default_nettype none

interface adcf_in_if;
    import adcf_pkg::*;

    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/adcf_out_if.sv -----
// Duty output channel: valid/ready handshake carrying one PWM duty value.
`timescale 1ns / 1ps
`default_nettype none

interface adcf_out_if;
    import adcf_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pwm_duty;

    modport source (output valid, output pwm_duty, input ready);
    modport sink   (input valid, input pwm_duty, output ready);
endinterface

`default_nettype wire

// ----- rtl/adcf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module adcf_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/audio_drive_crush_flanger.sv -----
// Top level: sample conditioning, drive, bitcrush, flanger and duty mapping pipeline.
//
// One sample beat is accepted every clock while the output side keeps up,
// and its duty beat follows through five registered stages: centring and
// noise gate, drive and bitcrush, flanger memory access (the sample is
// written and the delayed tap is read from the delay memory in the same
// cycle, one write and one read port), averaging, and the duty mapping into
// the output register. Every stage holds its beat only while the stage after
// it is full, so bubbles close up and a new sample is taken while a finished
// duty beat waits. Delay entries not yet written since reset read as zero
// through a fill count, so there is no clearing pass. The user must write
// configuration through the plain write port only while the pipeline is
// empty; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module audio_drive_crush_flanger #(
    parameter int DELAY_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [adcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    adcf_in_if.sink                           adc,
    adcf_out_if.source                        pwm
);
    import adcf_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int FW = $clog2(DELAY_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST_POS  = AW'(DELAY_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT  = FW'(DELAY_DEPTH);

    // configuration
    logic [9:0] baseline_reg;
    logic [9:0] noise_reg;
    logic [3:0] gain_reg;
    logic [3:0] crush_reg;
    logic [5:0] depth_reg;
    logic [1:0] rate_reg;
    logic [2:0] en_reg;

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic free1, free2, free3, free4, free_o;

    // pipeline payload
    sig_t              sig1_reg, sig2_reg, sig3_reg;
    logic              fl3_reg, fwd3_reg, tv3_reg;
    logic signed [11:0] s4_reg;
    logic [DUTY_W-1:0] duty_reg;

    // flanger state
    logic [AW-1:0] wp_reg, wp_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [6:0]    sv_reg, sv_next;
    logic          fall_reg;

    // stage 1
    sig_t             centred;
    logic [SIG_W-1:0] mag;
    sig_t             gated;

    // stage 2
    logic signed [15:0] prod;
    sig_t               driven, drive_sel, crushed;
    logic [3:0]         drop;
    logic [SIG_W-1:0]   mask;

    // stage 3
    logic          flange;
    logic          rev;
    logic [AW-1:0] svm_tab [128];
    logic [AW-1:0] svm;
    logic [AW:0]   tap_wide;
    logic [AW-1:0] tap;
    logic          fwd, tap_valid;
    logic          ram_we, ram_re;
    logic [SIG_W-1:0] ram_rdata;

    // stage 4
    sig_t               dly;
    logic signed [11:0] sum, sum_adj;
    sig_t               half, res;

    // output stage
    logic [17:0]       prod_x, qsum;
    logic [DUTY_W-1:0] duty_next;

    // handshake
    assign free_o = !out_valid_reg || pwm.ready;
    assign free4  = !v4_reg || free_o;
    assign free3  = !v3_reg || free4;
    assign free2  = !v2_reg || free3;
    assign free1  = !v1_reg || free2;

    assign adc.ready    = free1;
    assign pwm.valid    = out_valid_reg;
    assign pwm.pwm_duty = duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg <= BASELINE_RST;
            noise_reg    <= NOISE_FLOOR_RST;
            gain_reg     <= DRIVE_GAIN_RST;
            crush_reg    <= CRUSH_BITS_RST;
            depth_reg    <= SWEEP_DEPTH_RST;
            rate_reg     <= SWEEP_RATE_RST;
            en_reg       <= EFFECT_EN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASELINE:    baseline_reg <= cfg_data[9:0];
                CFG_NOISE_FLOOR: noise_reg    <= cfg_data[9:0];
                CFG_DRIVE_GAIN:  gain_reg     <= cfg_data[3:0];
                CFG_CRUSH_BITS:  crush_reg    <= cfg_data[3:0];
                CFG_SWEEP_DEPTH: depth_reg    <= cfg_data[5:0];
                CFG_SWEEP_RATE:  rate_reg     <= cfg_data[1:0];
                CFG_EFFECT_EN:   en_reg       <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // stage 1: centre, invert, gate
    always_comb
    begin
        centred = $signed({1'b0, baseline_reg}) - $signed({1'b0, adc.adc_sample});
        mag     = centred[SIG_W-1] ? SIG_W'(-centred) : SIG_W'(centred);
        gated   = (mag < {1'b0, noise_reg}) ? '0 : centred;
    end

    // stage 2: drive and bitcrush
    always_comb
    begin
        prod = $signed({{5{sig1_reg[SIG_W-1]}}, sig1_reg}) * $signed({12'd0, gain_reg});
        if (prod < -16'sd512)
        begin
            driven = -11'sd512;
        end
        else if (prod > 16'sd511)
        begin
            driven = 11'sd511;
        end
        else
        begin
            driven = prod[SIG_W-1:0];
        end
        drive_sel = en_reg[EN_DRIVE] ? driven : sig1_reg;
        drop      = (crush_reg >= 4'd8) ? 4'd0 : 4'd8 - crush_reg;
        mask      = SIG_W'({SIG_W{1'b1}} << drop);
        crushed   = en_reg[EN_CRUSH] ? (drive_sel & mask) : drive_sel;
    end

    // sweep offset modulo the delay depth, worked out at elaboration
    for (genvar g = 0; g < 128; g++)
    begin : g_svm
        assign svm_tab[g] = AW'(((g - 64) % DELAY_DEPTH + DELAY_DEPTH) % DELAY_DEPTH);
    end

    // stage 3: sweep step, delay write and tap read
    always_comb
    begin
        flange  = v2_reg && en_reg[EN_FLANGE];
        sv_next = fall_reg ? sv_reg - {5'd0, rate_reg} : sv_reg + {5'd0, rate_reg};
        rev     = ($signed(sv_next) >= $signed({1'b0, depth_reg})) ||
                  ($signed(sv_next) <= 7'sd0);
        svm     = svm_tab[sv_next ^ 7'h40];
        if (wp_reg >= svm)
        begin
            tap_wide = {1'b0, wp_reg} - {1'b0, svm};
        end
        else
        begin
            tap_wide = {1'b0, wp_reg} + DEPTH_EXT - {1'b0, svm};
        end
        tap       = tap_wide[AW-1:0];
        fwd       = (tap == wp_reg);
        tap_valid = FW'(tap) < fill_reg;
        wp_next   = (wp_reg == LAST_POS) ? '0 : wp_reg + 1'b1;
        fill_next = (fill_reg == FULL_CNT) ? fill_reg : fill_reg + 1'b1;
        ram_we    = free3 && flange;
        ram_re    = free3 && flange;
    end

    adcf_ram #(
        .WIDTH (SIG_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (sig2_reg),
        .re    (ram_re),
        .raddr (tap),
        .rdata (ram_rdata)
    );

    // stage 4: average with tap, truncating toward zero, then offset
    always_comb
    begin
        if (fwd3_reg)
        begin
            dly = sig3_reg;
        end
        else if (tv3_reg)
        begin
            dly = $signed(ram_rdata);
        end
        else
        begin
            dly = '0;
        end
        sum     = {sig3_reg[SIG_W-1], sig3_reg} + {dly[SIG_W-1], dly};
        sum_adj = sum + {11'd0, sum[11]};
        half    = sum_adj[11:1];
        res     = fl3_reg ? half : sig3_reg;
    end

    // output stage: (s * 255) / 1023 with saturation
    always_comb
    begin
        prod_x = 18'(s4_reg[9:0]) * 18'd255;
        qsum   = prod_x + (prod_x >> 10) + 18'd1;
        if (s4_reg[11] || s4_reg == 12'sd0)
        begin
            duty_next = '0;
        end
        else if (s4_reg >= 12'sd1023)
        begin
            duty_next = '1;
        end
        else
        begin
            duty_next = qsum[17:10];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sv_reg        <= '0;
            fall_reg      <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= adc.valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (free4)
            begin
                v4_reg <= v3_reg;
            end
            if (free_o)
            begin
                out_valid_reg <= v4_reg;
            end
            if (free3 && flange)
            begin
                wp_reg   <= wp_next;
                fill_reg <= fill_next;
                sv_reg   <= sv_next;
                fall_reg <= fall_reg ^ rev;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            sig1_reg <= gated;
        end
        if (free2)
        begin
            sig2_reg <= crushed;
        end
        if (free3)
        begin
            sig3_reg <= sig2_reg;
            fl3_reg  <= flange;
            fwd3_reg <= fwd;
            tv3_reg  <= tap_valid;
        end
        if (free4)
        begin
            s4_reg <= {res[SIG_W-1], res} + 12'sd512;
        end
        if (free_o)
        begin
            duty_reg <= duty_next;
        end
    end

    // assertions
    a_fill_tracks_wp: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != FULL_CNT) |-> (wp_reg == fill_reg[AW-1:0]))
        else $error("write position out of step with fill count");

    a_tap_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !free4) |=> (v3_reg && $stable(sig3_reg) && $stable(ram_rdata)))
        else $error("tap stage lost its beat while stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (adc.valid && adc.ready) |=> v1_reg)
        else $error("accepted beat missing from first stage");

endmodule

`default_nettype wire

// ----- sim/audio_drive_crush_flanger_checker.sv -----
// Checker: mirrors the register file, predicts each duty beat and compares on the output channel.
`timescale 1ns / 1ps

module audio_drive_crush_flanger_checker
    import adcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    adcf_in_if                    adc,
    adcf_out_if                   pwm,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    logic [9:0]        base_r;
    logic [9:0]        floor_r;
    logic [3:0]        gain_r;
    logic [3:0]        crush_r;
    logic [5:0]        depth_r;
    logic [1:0]        rate_r;
    logic [2:0]        en_r;

    sig_t              echo [64];
    logic [5:0]        wr_pos;
    logic signed [6:0] sweep;
    logic              falling;

    logic [DUTY_W-1:0] duty_due [$];

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("ERROR t=%0t %s: got %0d, want %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [7:0] predict_duty(input logic [9:0] raw);
        int         s;
        int         mag;
        int         drop;
        int         delayed;
        int         d;
        logic [11:0] kept;
        logic [5:0] tap;
        s = int'(base_r) - int'(raw);
        mag = (s < 0) ? -s : s;
        if (mag < int'(floor_r))
            s = 0;
        if (en_r[EN_DRIVE])
        begin
            s = s * int'(gain_r);
            if (s < -512)
                s = -512;
            if (s > 511)
                s = 511;
        end
        if (en_r[EN_CRUSH])
        begin
            drop = (crush_r >= 4'd8) ? 0 : 8 - int'(crush_r);
            kept = s[11:0] & (12'hFFF << drop);
            s = int'($signed(kept));
        end
        if (en_r[EN_FLANGE])
        begin
            echo[wr_pos] = sig_t'(s);
            if (falling)
                sweep = sweep - 7'(rate_r);
            else
                sweep = sweep + 7'(rate_r);
            if (int'(sweep) >= int'(depth_r) || int'(sweep) <= 0)
                falling = !falling;
            // tap sits after the write, so zero distance returns this sample
            tap = wr_pos - sweep[5:0];
            delayed = int'(echo[tap]);
            s = (s + delayed) / 2;
            wr_pos = wr_pos + 6'd1;
        end
        d = ((s + 512) * 255) / 1023;
        if (d < 0)
            d = 0;
        if (d > 255)
            d = 255;
        return d[7:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_r     = BASELINE_RST;
            floor_r    = NOISE_FLOOR_RST;
            gain_r     = DRIVE_GAIN_RST;
            crush_r    = CRUSH_BITS_RST;
            depth_r    = SWEEP_DEPTH_RST;
            rate_r     = SWEEP_RATE_RST;
            en_r       = EFFECT_EN_RST;
            for (int i = 0; i < 64; i++)
                echo[i] = '0;
            wr_pos     = '0;
            sweep      = '0;
            falling    = 1'b0;
            duty_due.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BASELINE:    base_r  = cfg_data[9:0];
                    CFG_NOISE_FLOOR: floor_r = cfg_data[9:0];
                    CFG_DRIVE_GAIN:  gain_r  = cfg_data[3:0];
                    CFG_CRUSH_BITS:  crush_r = cfg_data[3:0];
                    CFG_SWEEP_DEPTH: depth_r = cfg_data[5:0];
                    CFG_SWEEP_RATE:  rate_r  = cfg_data[1:0];
                    CFG_EFFECT_EN:   en_r    = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (pwm.valid && pwm.ready)
            begin
                checked++;
                if (duty_due.size() == 0)
                    report_mismatch("duty beat with nothing expected", pwm.pwm_duty, 8'd0);
                else
                begin
                    if (pwm.pwm_duty !== duty_due[0])
                        report_mismatch("pwm_duty", pwm.pwm_duty, duty_due[0]);
                    void'(duty_due.pop_front());
                end
            end
            if (adc.valid && adc.ready)
                duty_due.push_back(predict_duty(adc.adc_sample));
            pending = duty_due.size();
        end
    end

endmodule

// ----- sim/audio_drive_crush_flanger_tb.sv -----
// Testbench top: clock, reset, register setups, sample and duty channel drivers, verdict.
`timescale 1ns / 1ps

module audio_drive_crush_flanger_tb;
    import adcf_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    hold_req;
    bit                    calm;
    int                    fail_count;
    int                    pending;
    int                    checked;
    int                    setups;
    logic [9:0]            cur_base;

    logic [9:0] gated_edges [10] = '{10'd0, 10'd1023, 10'd290, 10'd240, 10'd241,
                                     10'd339, 10'd340, 10'd1, 10'd1022, 10'd512};
    logic [9:0] rails [5] = '{10'd0, 10'd1023, 10'd512, 10'd511, 10'd513};

    adcf_in_if  adc_ch ();
    adcf_out_if pwm_ch ();

    audio_drive_crush_flanger dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .adc       (adc_ch),
        .pwm       (pwm_ch)
    );

    audio_drive_crush_flanger_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .adc        (adc_ch),
        .pwm        (pwm_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_sample(input logic [9:0] raw);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            adc_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        adc_ch.valid      = 1'b1;
        adc_ch.adc_sample = raw;
        do
            @(posedge clk);
        while (!adc_ch.ready);
        @(negedge clk);
    endtask

    task automatic run_samples(input int n);
        int         t;
        logic [9:0] raw;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0, 1: raw = 10'($urandom_range(0, 1023));
                2:
                begin
                    t = int'(cur_base) + int'($urandom_range(0, 200)) - 100;
                    if (t < 0)
                        t = 0;
                    if (t > 1023)
                        t = 1023;
                    raw = t[9:0];
                end
                default: raw = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            endcase
            send_sample(raw);
        end
    endtask

    task automatic drain();
        adc_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic apply_setup(input logic [9:0] base, input logic [9:0] floor_v,
                               input logic [3:0] gain, input logic [3:0] crush,
                               input logic [5:0] depth, input logic [1:0] rate,
                               input logic [2:0] en);
        drain();
        set_reg(CFG_BASELINE, base);
        set_reg(CFG_NOISE_FLOOR, 10'(floor_v));
        set_reg(CFG_DRIVE_GAIN, 10'(gain));
        set_reg(CFG_CRUSH_BITS, 10'(crush));
        set_reg(CFG_SWEEP_DEPTH, 10'(depth));
        set_reg(CFG_SWEEP_RATE, 10'(rate));
        set_reg(CFG_EFFECT_EN, 10'(en));
        cur_base = base;
        setups++;
    endtask

    // output side: random short stalls, plus one long hold-off on request
    initial
    begin
        pwm_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n)
                pwm_ch.ready = 1'b0;
            else if (hold_req)
            begin
                pwm_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req     = 1'b0;
                pwm_ch.ready = 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                pwm_ch.ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                pwm_ch.ready = 1'b1;
            end
            else
                pwm_ch.ready = 1'b1;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        adc_ch.valid      = 1'b0;
        adc_ch.adc_sample = '0;
        hold_req          = 1'b0;
        calm              = 1'b0;
        setups            = 0;
        cur_base          = BASELINE_RST;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // defaults: gate edges and full-scale samples through drive
        apply_setup(10'd290, 10'd50, 4'd4, 4'd5, 6'd30, 2'd1, 3'd1);
        foreach (gated_edges[i])
            send_sample(gated_edges[i]);
        // all effects, gate off, gain 15, full crush, sweep held at depth 0
        apply_setup(10'd512, 10'd0, 4'd15, 4'd0, 6'd0, 2'd0, 3'd7);
        foreach (rails[i])
            send_sample(rails[i]);
        // zero gain, crush of 8 keeps everything, floor at max
        apply_setup(10'd0, 10'd1023, 4'd0, 4'd8, 6'd32, 2'd3, 3'd3);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd5);
        // crush over range plus flanger, drive off
        apply_setup(10'd1023, 10'd0, 4'd8, 4'd15, 6'd1, 2'd2, 3'd6);
        foreach (rails[i])
            send_sample(rails[i]);

        // deep sweep so the 7-bit sweep wraps and the tap distance hits zero
        apply_setup(10'd290, 10'd0, 4'd1, 4'd8, 6'd63, 2'd3, 3'd4);
        run_samples(60);
        apply_setup(10'd290, 10'd0, 4'd1, 4'd8, 6'd63, 2'd2, 3'd4);
        run_samples(60);

        for (int p = 0; p < 8; p++)
        begin
            if (p >= 6)
                calm = 1'b1;
            apply_setup($urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
                                                  : 10'($urandom_range(200, 800)),
                        $urandom_range(0, 3) == 0 ? 10'($urandom_range(0, 1023))
                                                  : 10'($urandom_range(0, 80)),
                        4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                        6'($urandom_range(0, 63)), 2'($urandom_range(0, 3)),
                        3'($urandom_range(0, 7)));
            if (p == 2)
            begin
                run_samples(5);
                hold_req = 1'b1;
                run_samples(25);
            end
            else
                run_samples(30);
            if (p == 4)
            begin
                apply_setup(10'd1023, 10'd1023, 4'd15, 4'd15, 6'd63, 2'd3, 3'd7);
                run_samples(20);
                apply_setup(10'd0, 10'd0, 4'd0, 4'd0, 6'd0, 2'd0, 3'd0);
                run_samples(20);
            end
        end

        drain();
        $display("Checked %0d duty beats over %0d register setups, with gate edges, rails,",
                 checked, setups);
        $display("sweep wrap and a %0d-cycle output hold-off.", HOLD_CYCLES);
        if (fail_count == 0)
            $display("audio_drive_crush_flanger: match");
        else
            $display("audio_drive_crush_flanger: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d duty beats still expected", pending);
        $display("audio_drive_crush_flanger: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/adcf_pkg.sv
rtl/adcf_in_if.sv
rtl/adcf_out_if.sv
rtl/adcf_ram.sv
rtl/audio_drive_crush_flanger.sv
sim/audio_drive_crush_flanger_checker.sv
sim/audio_drive_crush_flanger_tb.sv
